/* design/i2ccw_pkg.sv */
// Shared types and constants for the I2C command writer with address fallback.
package i2ccw_pkg;

    localparam int ADDR_W = 7;

    // Action codes on the request channel
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_CMD   = 2'd1;
    localparam logic [1:0] ACT_PROBE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_BIT_DELAY = 2'd0;
    localparam logic [1:0] CFG_PRIMARY_ADDR   = 2'd1;
    localparam logic [1:0] CFG_ALTERNATE_ADDR = 2'd2;

    localparam logic [7:0] CTRL_BYTE = 8'h00;

    typedef enum logic [1:0] {
        K_TICK,
        K_CMD,
        K_PROBE,
        K_NONE
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE,
        PH_START_A,
        PH_START_B,
        PH_START_C,
        PH_BIT_DATA,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_ACK_REL,
        PH_ACK_HIGH,
        PH_ACK_LOW,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] command_byte;
        logic       sda_sense;
    } t_item;

    typedef struct packed {
        logic scl_drive_low;
        logic sda_drive_low;
        logic busy_res;
        logic done_res;
        logic acked;
        logic used_alternate;
        logic request_ignored;
    } t_result;

    function automatic t_kind classify(input logic [1:0] action);
        t_kind k;
        case (action)
            ACT_TICK:  k = K_TICK;
            ACT_CMD:   k = K_CMD;
            ACT_PROBE: k = K_PROBE;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

/* design/i2ccw_in_if.sv */
// Request channel: action beats with command byte and sensed SDA level.
interface i2ccw_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] command_byte;
    logic       sda_sense;

    modport source (output valid, output action, output command_byte, output sda_sense,
                    input ready);
    modport sink   (input valid, input action, input command_byte, input sda_sense,
                    output ready);
endinterface

/* design/i2ccw_out_if.sv */
// Result channel: line drives and status flags, one beat per request beat.
interface i2ccw_out_if;
    logic valid;
    logic ready;
    logic scl_drive_low;
    logic sda_drive_low;
    logic busy_res;
    logic done_res;
    logic acked;
    logic used_alternate;
    logic request_ignored;

    modport source (output valid, output scl_drive_low, output sda_drive_low,
                    output busy_res, output done_res, output acked,
                    output used_alternate, output request_ignored, input ready);
    modport sink   (input valid, input scl_drive_low, input sda_drive_low,
                    input busy_res, input done_res, input acked,
                    input used_alternate, input request_ignored, output ready);
endinterface

/* design/i2ccw_front.sv */
// Front end: accepts request beats, classifies the action, queues two deep.
module i2ccw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2ccw_in_if.sink          i_req,
    input  logic              i_pop,
    output logic              o_item_valid,
    output i2ccw_pkg::t_item  o_item
);

    i2ccw_pkg::t_item r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             push;
    logic             pop;

    assign i_req.ready  = (r_count != 2'd2);
    assign push         = i_req.valid && i_req.ready;
    assign o_item_valid = (r_count != 2'd0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr].kind         <= i2ccw_pkg::classify(i_req.action);
            r_mem[r_wr_ptr].command_byte <= i_req.command_byte;
            r_mem[r_wr_ptr].sda_sense    <= i_req.sda_sense;
        end
    end

endmodule

/* design/i2ccw_back.sv */
// Back end: bit-bang sequencer, one queued beat per cycle while the result is not stalled, registered result.
module i2ccw_back #(
    parameter int DELAY_W = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [DELAY_W-1:0]            i_half_bit_delay,
    input  logic [i2ccw_pkg::ADDR_W-1:0]  i_primary_address,
    input  logic [i2ccw_pkg::ADDR_W-1:0]  i_alternate_address,
    input  logic                          i_item_valid,
    input  i2ccw_pkg::t_item              i_item,
    output logic                          o_pop,
    i2ccw_out_if.source                   o_res
);

    i2ccw_pkg::t_phase   r_phase, n_phase;
    logic [3:0]          r_bit, n_bit;
    logic [7:0]          r_shift, n_shift;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    logic [1:0]          r_byte, n_byte;
    logic                r_try, n_try;
    logic                r_probe, n_probe;
    logic [7:0]          r_saved, n_saved;
    logic                r_ack, n_ack;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic                r_out_valid;
    i2ccw_pkg::t_result  r_res, n_res;

    logic                enter;
    logic                load;
    i2ccw_pkg::t_phase   ent_ph;
    logic [DELAY_W-1:0]  dec;
    logic [i2ccw_pkg::ADDR_W-1:0] addr;

    assign o_pop = i_item_valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_delay = r_delay;
        n_byte  = r_byte;
        n_try   = r_try;
        n_probe = r_probe;
        n_saved = r_saved;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_res   = '0;
        enter   = 1'b0;
        load    = 1'b0;
        ent_ph  = i2ccw_pkg::PH_IDLE;
        dec     = (r_delay != '0) ? r_delay - DELAY_W'(1) : '0;

        if (o_pop) begin
            case (i_item.kind)
                i2ccw_pkg::K_CMD, i2ccw_pkg::K_PROBE: begin
                    if (r_phase != i2ccw_pkg::PH_IDLE) begin
                        n_res.request_ignored = 1'b1;
                    end else begin
                        n_probe = (i_item.kind == i2ccw_pkg::K_PROBE);
                        if (i_item.kind == i2ccw_pkg::K_CMD) begin
                            n_saved = i_item.command_byte;
                        end
                        n_try  = 1'b0;
                        n_byte = 2'd0;
                        n_ack  = 1'b0;
                        n_bit  = 4'd0;
                        enter  = 1'b1;
                        ent_ph = n_probe ? i2ccw_pkg::PH_PRE : i2ccw_pkg::PH_START_A;
                    end
                end
                i2ccw_pkg::K_TICK: begin
                    if (r_phase != i2ccw_pkg::PH_IDLE) begin
                        n_delay = dec;
                        if (dec == '0) begin
                            enter = 1'b1;
                            case (r_phase)
                                i2ccw_pkg::PH_PRE:     ent_ph = i2ccw_pkg::PH_START_A;
                                i2ccw_pkg::PH_START_A: ent_ph = i2ccw_pkg::PH_START_B;
                                i2ccw_pkg::PH_START_B: ent_ph = i2ccw_pkg::PH_START_C;
                                i2ccw_pkg::PH_START_C: begin
                                    load   = 1'b1;
                                    ent_ph = i2ccw_pkg::PH_BIT_DATA;
                                end
                                i2ccw_pkg::PH_BIT_DATA: ent_ph = i2ccw_pkg::PH_BIT_HIGH;
                                i2ccw_pkg::PH_BIT_HIGH: ent_ph = i2ccw_pkg::PH_BIT_LOW;
                                i2ccw_pkg::PH_BIT_LOW: begin
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_bit   = r_bit + 4'd1;
                                    ent_ph  = (n_bit >= 4'd8) ? i2ccw_pkg::PH_ACK_REL
                                                              : i2ccw_pkg::PH_BIT_DATA;
                                end
                                i2ccw_pkg::PH_ACK_REL: ent_ph = i2ccw_pkg::PH_ACK_HIGH;
                                i2ccw_pkg::PH_ACK_HIGH: begin
                                    n_ack  = !i_item.sda_sense;
                                    ent_ph = i2ccw_pkg::PH_ACK_LOW;
                                end
                                i2ccw_pkg::PH_ACK_LOW: begin
                                    if (r_ack && !r_probe && r_byte < 2'd2) begin
                                        n_byte = r_byte + 2'd1;
                                        load   = 1'b1;
                                        ent_ph = i2ccw_pkg::PH_BIT_DATA;
                                    end else begin
                                        ent_ph = i2ccw_pkg::PH_STOP_A;
                                    end
                                end
                                i2ccw_pkg::PH_STOP_A: ent_ph = i2ccw_pkg::PH_STOP_B;
                                i2ccw_pkg::PH_STOP_B: ent_ph = i2ccw_pkg::PH_STOP_C;
                                i2ccw_pkg::PH_STOP_C: begin
                                    if (!r_ack && !r_try) begin
                                        // primary NACKed: redo the attempt at the alternate
                                        n_try  = 1'b1;
                                        n_byte = 2'd0;
                                        n_ack  = 1'b0;
                                        n_bit  = 4'd0;
                                        ent_ph = i2ccw_pkg::PH_START_A;
                                    end else begin
                                        enter                = 1'b0;
                                        n_res.done_res       = 1'b1;
                                        n_res.acked          = r_ack;
                                        n_res.used_alternate = r_try;
                                        n_phase              = i2ccw_pkg::PH_IDLE;
                                        n_delay              = '0;
                                    end
                                end
                                default: begin
                                    enter   = 1'b0;
                                    n_phase = i2ccw_pkg::PH_IDLE;
                                    n_delay = '0;
                                end
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end

        if (load) begin
            addr = n_try ? i_alternate_address : i_primary_address;
            case (n_byte)
                2'd0:    n_shift = {addr, 1'b0};
                2'd1:    n_shift = i2ccw_pkg::CTRL_BYTE;
                default: n_shift = r_saved;
            endcase
            n_bit = 4'd0;
        end else begin
            addr = i_primary_address;
        end

        if (enter) begin
            n_phase = ent_ph;
            n_delay = i_half_bit_delay;
            case (ent_ph)
                i2ccw_pkg::PH_PRE, i2ccw_pkg::PH_START_A: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                i2ccw_pkg::PH_START_B:  n_sda = 1'b1;
                i2ccw_pkg::PH_START_C:  n_scl = 1'b1;
                i2ccw_pkg::PH_BIT_DATA: n_sda = !n_shift[7];
                i2ccw_pkg::PH_BIT_HIGH: n_scl = 1'b0;
                i2ccw_pkg::PH_BIT_LOW:  n_scl = 1'b1;
                i2ccw_pkg::PH_ACK_REL:  n_sda = 1'b0;
                i2ccw_pkg::PH_ACK_HIGH: n_scl = 1'b0;
                i2ccw_pkg::PH_ACK_LOW:  n_scl = 1'b1;
                i2ccw_pkg::PH_STOP_A:   n_sda = 1'b1;
                i2ccw_pkg::PH_STOP_B:   n_scl = 1'b0;
                i2ccw_pkg::PH_STOP_C:   n_sda = 1'b0;
                default:                n_delay = '0;
            endcase
        end

        n_res.scl_drive_low = n_scl;
        n_res.sda_drive_low = n_sda;
        n_res.busy_res      = (n_phase != i2ccw_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2ccw_pkg::PH_IDLE;
            r_bit       <= 4'd0;
            r_shift     <= 8'd0;
            r_delay     <= '0;
            r_byte      <= 2'd0;
            r_try       <= 1'b0;
            r_probe     <= 1'b0;
            r_saved     <= 8'd0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_delay     <= n_delay;
                r_byte      <= n_byte;
                r_try       <= n_try;
                r_probe     <= n_probe;
                r_saved     <= n_saved;
                r_ack       <= n_ack;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.scl_drive_low   = r_res.scl_drive_low;
    assign o_res.sda_drive_low   = r_res.sda_drive_low;
    assign o_res.busy_res        = r_res.busy_res;
    assign o_res.done_res        = r_res.done_res;
    assign o_res.acked           = r_res.acked;
    assign o_res.used_alternate  = r_res.used_alternate;
    assign o_res.request_ignored = r_res.request_ignored;

endmodule

/* design/i2c_command_writer_with_fallback_core.sv */
// Top level: I2C command writer with alternate-address fallback.
//
//  channel   dir  beat contents                                   handshake
//  i_req     in   action, command_byte, sda_sense                 valid/ready
//  o_res     out  scl/sda drive, busy, done, acked, used_alt,     valid/ready
//                 request_ignored
//  i_cfg_*   in   register index, write data                      write enable
//
// Every request beat yields exactly one result beat, in order.
// Sustained rate: one beat per cycle while o_res is not stalled; each beat
// passes the queue, then the sequencer step that writes the result register.
// Front end holds a two-deep queue, so i_req.ready only drops when the
// result register is stalled and the queue has filled behind it.
// Reset (i_rst_n low, synchronous) idles the bus with both lines released
// and restores delay 5, primary 0x3C, alternate 0x3D.
module i2c_command_writer_with_fallback_core #(
    parameter int MAX_HALF_BIT_DELAY = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2ccw_in_if.sink    i_req,
    i2ccw_out_if.source o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [((($clog2(MAX_HALF_BIT_DELAY + 1)) > i2ccw_pkg::ADDR_W) ?
                   $clog2(MAX_HALF_BIT_DELAY + 1) : i2ccw_pkg::ADDR_W) - 1 : 0] i_cfg_data
);

    localparam int DELAY_W = $clog2(MAX_HALF_BIT_DELAY + 1);
    localparam int CFG_W   = (DELAY_W > i2ccw_pkg::ADDR_W) ? DELAY_W : i2ccw_pkg::ADDR_W;
    localparam int RST_DLY = (MAX_HALF_BIT_DELAY < 5) ? MAX_HALF_BIT_DELAY : 5;

    logic [DELAY_W-1:0]           r_half_bit_delay;
    logic [i2ccw_pkg::ADDR_W-1:0] r_primary_address;
    logic [i2ccw_pkg::ADDR_W-1:0] r_alternate_address;
    logic [CFG_W-1:0]             sat_delay;

    logic             item_valid;
    logic             pop;
    i2ccw_pkg::t_item item;

    // delay writes clamp into 1..MAX
    always_comb begin
        if (i_cfg_data == '0) begin
            sat_delay = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_HALF_BIT_DELAY)) begin
            sat_delay = CFG_W'(MAX_HALF_BIT_DELAY);
        end else begin
            sat_delay = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_delay    <= DELAY_W'(RST_DLY);
            r_primary_address   <= 7'h3C;
            r_alternate_address <= 7'h3D;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2ccw_pkg::CFG_HALF_BIT_DELAY: r_half_bit_delay    <= sat_delay[DELAY_W-1:0];
                i2ccw_pkg::CFG_PRIMARY_ADDR:   r_primary_address   <= i_cfg_data[6:0];
                i2ccw_pkg::CFG_ALTERNATE_ADDR: r_alternate_address <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    i2ccw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_pop        (pop),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    i2ccw_back #(
        .DELAY_W (DELAY_W)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_half_bit_delay    (r_half_bit_delay),
        .i_primary_address   (r_primary_address),
        .i_alternate_address (r_alternate_address),
        .i_item_valid        (item_valid),
        .i_item              (item),
        .o_pop               (pop),
        .o_res               (o_res)
    );

endmodule

/* design/i2ccw_checker.sv */
// Port-level checks for the I2C command writer, bound to the top level.
module i2ccw_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_scl_drive_low,
    input logic i_sda_drive_low,
    input logic i_busy_res,
    input logic i_done_res,
    input logic i_acked,
    input logic i_used_alternate,
    input logic i_request_ignored
);

    a_reset_no_beat: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result beat right after reset");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_done_res |-> !i_busy_res && !i_request_ignored)
        else $error("done beat while still busy or flagged ignored");

    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_done_res |-> !i_acked && !i_used_alternate)
        else $error("acked/used_alternate without done");

    a_ignored_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_request_ignored |-> i_busy_res)
        else $error("request dropped while idle");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable({i_scl_drive_low,
            i_sda_drive_low, i_busy_res, i_done_res, i_acked, i_used_alternate,
            i_request_ignored}))
        else $error("stalled result beat changed");

endmodule

bind i2c_command_writer_with_fallback_core i2ccw_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_scl_drive_low   (o_res.scl_drive_low),
    .i_sda_drive_low   (o_res.sda_drive_low),
    .i_busy_res        (o_res.busy_res),
    .i_done_res        (o_res.done_res),
    .i_acked           (o_res.acked),
    .i_used_alternate  (o_res.used_alternate),
    .i_request_ignored (o_res.request_ignored)
);
